// ===== src/ngram_fitness_scorer_core_defines.svh =====
// assertion macros for the n-gram fitness scorer
`ifndef NGRAM_FITNESS_SCORER_CORE_DEFINES_SVH
`define NGRAM_FITNESS_SCORER_CORE_DEFINES_SVH

// check on clk, off while rst_n is low
`define NGFS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on clk, also during reset
`define NGFS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ngfs_pkg.sv =====
// shared types, codes and defaults of the n-gram fitness scorer
package ngfs_pkg;

  localparam int unsigned ALPHABET_SIZE_DEF = 26;
  localparam int unsigned WEIGHT_WIDTH_DEF  = 16;
  localparam int unsigned SUM_WIDTH_DEF     = 32;

  localparam int unsigned SCORE_WIDTH = 32;
  localparam int unsigned INDEX_WIDTH = 24;
  localparam int unsigned VALUE_WIDTH = 16;
  localparam int unsigned NUM_TABLES  = 4;

  localparam int unsigned OUT_DEPTH  = 4;
  localparam int unsigned OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  localparam logic REQ_SCORE = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic [1:0] TBL_BI    = 2'd0;
  localparam logic [1:0] TBL_TRI   = 2'd1;
  localparam logic [1:0] TBL_TETRA = 2'd2;
  localparam logic [1:0] TBL_PENTA = 2'd3;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

  typedef struct packed {
    logic       ok;
    logic [4:0] code;
  } letter_t;

  function automatic letter_t letter_decode(input logic [7:0] c);
    letter_t r;
    r.ok   = 1'b0;
    r.code = '0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r.ok   = 1'b1;
      r.code = 5'(c - CHAR_UPPER_A);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      r.ok   = 1'b1;
      r.code = 5'(c - CHAR_LOWER_A);
    end
    return r;
  endfunction

endpackage

// ===== src/ngfs_ram.sv =====
// generic single-write, single-read ram with registered read data
module ngfs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 676
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/ngram_fitness_scorer_core.sv =====
// top level of the streaming n-gram fitness scorer
// throughput: one item per cycle while in_ready is high, write and score items alike
// the score of a text passes the read stage, the final stage and the output queue before it is offered
// each character issues up to four table reads at once, sums update in the next cycle
// in_ready drops while four scores are in flight or queued, and during reset
// reset clears letter history, sums and output queue; weight tables are not cleared
`include "ngram_fitness_scorer_core_defines.svh"
module ngram_fitness_scorer_core #(
  parameter int unsigned ALPHABET_SIZE = ngfs_pkg::ALPHABET_SIZE_DEF,
  parameter int unsigned WEIGHT_WIDTH  = ngfs_pkg::WEIGHT_WIDTH_DEF,
  parameter int unsigned SUM_WIDTH     = ngfs_pkg::SUM_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_req_type,
  input  logic [7:0]                          in_char_code,
  input  logic                                in_last,
  input  logic [1:0]                          in_table_select,
  input  logic [ngfs_pkg::INDEX_WIDTH-1:0]    in_table_index,
  input  logic [ngfs_pkg::VALUE_WIDTH-1:0]    in_table_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ngfs_pkg::SCORE_WIDTH-1:0]    out_score
);

  localparam int unsigned LW  = $clog2(ALPHABET_SIZE);
  localparam int unsigned D2  = ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int unsigned D3  = D2 * ALPHABET_SIZE;
  localparam int unsigned D4  = D3 * ALPHABET_SIZE;
  localparam int unsigned D5  = D4 * ALPHABET_SIZE;
  localparam int unsigned IW2 = $clog2(D2);
  localparam int unsigned IW3 = $clog2(D3);
  localparam int unsigned IW4 = $clog2(D4);
  localparam int unsigned IW5 = $clog2(D5);
  localparam int unsigned ADD_W = ((SUM_WIDTH > WEIGHT_WIDTH) ? SUM_WIDTH : WEIGHT_WIDTH) + 1;
  localparam int unsigned TOT_W = ((SUM_WIDTH + 2) > (ngfs_pkg::SCORE_WIDTH + 1)) ?
                                  (SUM_WIDTH + 2) : (ngfs_pkg::SCORE_WIDTH + 1);
  localparam int unsigned NT = ngfs_pkg::NUM_TABLES;

  // input side
  logic              in_acc;
  logic              is_write;
  logic              score_acc;
  ngfs_pkg::letter_t lt;
  logic              cur_ok;
  logic [LW-1:0]     cur;
  logic [IW2-1:0]    idx2;
  logic [IW3-1:0]    idx3;
  logic [IW4-1:0]    idx4;
  logic [IW5-1:0]    idx5;
  logic [NT-1:0]     rd_en;
  logic [NT-1:0]     wr_en;
  logic [WEIGHT_WIDTH-1:0] wr_val;

  // letter history as running n-gram indices
  logic [2:0]     run_r;
  logic [LW-1:0]  p1_r;
  logic [IW2-1:0] p2_r;
  logic [IW3-1:0] p3_r;
  logic [IW4-1:0] p4_r;

  // read stage
  logic                    s1_vld_r;
  logic                    s1_last_r;
  logic [NT-1:0]           s1_en_r;
  logic [WEIGHT_WIDTH-1:0] rd_w [NT];
  logic [ADD_W-1:0]        add_w [NT];
  logic [SUM_WIDTH-1:0]    sum_nxt [NT];
  logic [SUM_WIDTH-1:0]    sum_r [NT];

  // final stage
  logic                             fin_vld_r;
  logic [SUM_WIDTH-1:0]             fin_r [NT];
  logic [TOT_W-1:0]                 tot;
  logic [ngfs_pkg::SCORE_WIDTH-1:0] score_sat;

  // output queue
  logic [ngfs_pkg::SCORE_WIDTH-1:0] q_mem_r [ngfs_pkg::OUT_DEPTH];
  logic [ngfs_pkg::OUT_PTR_W-1:0]   wr_ptr_r;
  logic [ngfs_pkg::OUT_PTR_W-1:0]   rd_ptr_r;
  logic [ngfs_pkg::OUT_CNT_W-1:0]   q_cnt_r;
  logic [ngfs_pkg::OUT_CNT_W-1:0]   q_cnt_nxt;
  logic [ngfs_pkg::OUT_CNT_W-1:0]   pending_r;
  logic [ngfs_pkg::OUT_CNT_W-1:0]   pending_nxt;
  logic                             q_push;
  logic                             q_pop;
  logic                             last_acc;

  assign in_ready  = rst_n && (pending_r != ngfs_pkg::OUT_CNT_W'(ngfs_pkg::OUT_DEPTH));
  assign in_acc    = in_valid && in_ready;
  assign is_write  = in_req_type == ngfs_pkg::REQ_WRITE;
  assign score_acc = in_acc && !is_write;
  assign last_acc  = score_acc && in_last;

  always_comb begin
    lt     = ngfs_pkg::letter_decode(in_char_code);
    cur_ok = lt.ok && (32'(lt.code) < ALPHABET_SIZE);
    cur    = LW'(lt.code);
  end

  // each index extends the one that ended at the previous letter
  assign idx2 = IW2'(p1_r) * IW2'(ALPHABET_SIZE) + IW2'(cur);
  assign idx3 = IW3'(p2_r) * IW3'(ALPHABET_SIZE) + IW3'(cur);
  assign idx4 = IW4'(p3_r) * IW4'(ALPHABET_SIZE) + IW4'(cur);
  assign idx5 = IW5'(p4_r) * IW5'(ALPHABET_SIZE) + IW5'(cur);

  always_comb begin
    rd_en[0] = score_acc && cur_ok && (run_r >= 3'd1);
    rd_en[1] = score_acc && cur_ok && (run_r >= 3'd2);
    rd_en[2] = score_acc && cur_ok && (run_r >= 3'd3);
    rd_en[3] = score_acc && cur_ok && (run_r >= 3'd4);
  end

  always_comb begin
    wr_en[0] = in_acc && is_write && (in_table_select == ngfs_pkg::TBL_BI) &&
               (32'(in_table_index) < D2);
    wr_en[1] = in_acc && is_write && (in_table_select == ngfs_pkg::TBL_TRI) &&
               (32'(in_table_index) < D3);
    wr_en[2] = in_acc && is_write && (in_table_select == ngfs_pkg::TBL_TETRA) &&
               (32'(in_table_index) < D4);
    wr_en[3] = in_acc && is_write && (in_table_select == ngfs_pkg::TBL_PENTA) &&
               (32'(in_table_index) < D5);
  end

  assign wr_val = WEIGHT_WIDTH'(in_table_value);

  ngfs_ram #(.WIDTH(WEIGHT_WIDTH), .DEPTH(D2)) u_bi_ram (
    .clk(clk), .we(wr_en[0]), .waddr(IW2'(in_table_index)), .wdata(wr_val),
    .re(rd_en[0]), .raddr(idx2), .rdata(rd_w[0])
  );

  ngfs_ram #(.WIDTH(WEIGHT_WIDTH), .DEPTH(D3)) u_tri_ram (
    .clk(clk), .we(wr_en[1]), .waddr(IW3'(in_table_index)), .wdata(wr_val),
    .re(rd_en[1]), .raddr(idx3), .rdata(rd_w[1])
  );

  ngfs_ram #(.WIDTH(WEIGHT_WIDTH), .DEPTH(D4)) u_tetra_ram (
    .clk(clk), .we(wr_en[2]), .waddr(IW4'(in_table_index)), .wdata(wr_val),
    .re(rd_en[2]), .raddr(idx4), .rdata(rd_w[2])
  );

  ngfs_ram #(.WIDTH(WEIGHT_WIDTH), .DEPTH(D5)) u_penta_ram (
    .clk(clk), .we(wr_en[3]), .waddr(IW5'(in_table_index)), .wdata(wr_val),
    .re(rd_en[3]), .raddr(idx5), .rdata(rd_w[3])
  );

  // letter run length and running indices
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else if (score_acc) begin
      if (in_last || !cur_ok) begin
        run_r <= '0;
      end else if (run_r != 3'd4) begin
        run_r <= run_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (score_acc && cur_ok) begin
      p1_r <= cur;
      p2_r <= idx2;
      p3_r <= idx3;
      p4_r <= idx4;
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= score_acc;
    end
  end

  always_ff @(posedge clk) begin
    s1_last_r <= in_last;
    s1_en_r   <= rd_en;
  end

  // saturating accumulate
  always_comb begin
    for (int k = 0; k < NT; k++) begin
      add_w[k]   = ADD_W'(sum_r[k]) + ADD_W'(s1_en_r[k] ? rd_w[k] : '0);
      sum_nxt[k] = (|add_w[k][ADD_W-1:SUM_WIDTH]) ? '1 : add_w[k][SUM_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NT; k++) begin
        sum_r[k] <= '0;
      end
    end else if (s1_vld_r) begin
      for (int k = 0; k < NT; k++) begin
        sum_r[k] <= s1_last_r ? '0 : sum_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else begin
      fin_vld_r <= s1_vld_r && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && s1_last_r) begin
      for (int k = 0; k < NT; k++) begin
        fin_r[k] <= sum_nxt[k];
      end
    end
  end

  // combined score
  always_comb begin
    tot = TOT_W'(fin_r[3]) + TOT_W'(fin_r[2] >> 1) + TOT_W'(fin_r[1] >> 2) +
          TOT_W'(fin_r[0] >> 3);
    score_sat = (|tot[TOT_W-1:ngfs_pkg::SCORE_WIDTH]) ? '1 :
                tot[ngfs_pkg::SCORE_WIDTH-1:0];
  end

  // output queue and credit count
  assign q_push    = fin_vld_r;
  assign q_pop     = out_valid && out_ready;
  assign out_valid = q_cnt_r != '0;
  assign out_score = q_mem_r[rd_ptr_r];

  always_comb begin
    q_cnt_nxt   = q_cnt_r + ngfs_pkg::OUT_CNT_W'(q_push) - ngfs_pkg::OUT_CNT_W'(q_pop);
    pending_nxt = pending_r + ngfs_pkg::OUT_CNT_W'(last_acc) - ngfs_pkg::OUT_CNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      q_cnt_r   <= '0;
      pending_r <= '0;
    end else begin
      if (q_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      q_cnt_r   <= q_cnt_nxt;
      pending_r <= pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem_r[wr_ptr_r] <= score_sat;
    end
  end

  `NGFS_ASSERT_RST(a_pend_max, pending_r <= ngfs_pkg::OUT_CNT_W'(ngfs_pkg::OUT_DEPTH), "credit count over queue depth")
  `NGFS_ASSERT_RST(a_queue_le_pend, q_cnt_r <= pending_r, "queue holds more than credits")
  `NGFS_ASSERT_RST(a_last_to_fin, s1_vld_r && s1_last_r |=> fin_vld_r, "last item lost before final stage")
  `NGFS_ASSERT_RST(a_fin_to_queue, fin_vld_r |=> q_cnt_r != '0, "final score not queued")
  `NGFS_ASSERT_RST(a_write_no_read, in_valid && in_ready && in_req_type == ngfs_pkg::REQ_WRITE |=> !s1_vld_r, "write item entered read stage")

endmodule

// ===== verif/ngram_fitness_scorer_core_tb.sv =====
// self-checking testbench for the n-gram fitness scorer core
`timescale 1ns / 100ps
module ngram_fitness_scorer_core_tb;

  localparam int unsigned ALPHA       = ngfs_pkg::ALPHABET_SIZE_DEF;
  localparam logic [5:0]  NO_LETTER   = 6'd63;
  localparam int unsigned LONG_LEN    = 64;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 8;

  typedef struct packed {
    logic                                req;
    logic [7:0]                          ch;
    logic                                last;
    logic [1:0]                          sel;
    logic [ngfs_pkg::INDEX_WIDTH-1:0]    idx;
    logic [ngfs_pkg::VALUE_WIDTH-1:0]    val;
    logic                                chk;
    logic [ngfs_pkg::SCORE_WIDTH-1:0]    want;
  } scorer_item_t;

  logic                             clk;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic                             in_req_type = ngfs_pkg::REQ_SCORE;
  logic [7:0]                       in_char_code = '0;
  logic                             in_last = 1'b0;
  logic [1:0]                       in_table_select = ngfs_pkg::TBL_BI;
  logic [ngfs_pkg::INDEX_WIDTH-1:0] in_table_index = '0;
  logic [ngfs_pkg::VALUE_WIDTH-1:0] in_table_value = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [ngfs_pkg::SCORE_WIDTH-1:0] out_score;

  // scorer state as the block should hold it
  logic [5:0]                       history [4];
  logic [31:0]                      ngram_sum [4];
  logic [ngfs_pkg::VALUE_WIDTH-1:0] weights [bit [25:0]];
  logic [ngfs_pkg::SCORE_WIDTH-1:0] pending_scores [$];

  logic [4:0]  load_set [3];
  bit          idle_on = 1'b1;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned writes_sent = 0;
  int unsigned scores_checked = 0;
  int unsigned scores_saturated = 0;

  ngram_fitness_scorer_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_char_code    (in_char_code),
    .in_last         (in_last),
    .in_table_select (in_table_select),
    .in_table_index  (in_table_index),
    .in_table_value  (in_table_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_score       (out_score)
  );

  function automatic scorer_item_t text_item(input logic [7:0] c, input logic l);
    scorer_item_t s;
    s      = '0;
    s.req  = ngfs_pkg::REQ_SCORE;
    s.ch   = c;
    s.last = l;
    return s;
  endfunction

  // last item of a text whose score is plainly zero, such as a one-character or broken text
  function automatic scorer_item_t zero_item(input logic [7:0] c);
    scorer_item_t s;
    s     = text_item(c, 1'b1);
    s.chk = 1'b1;
    return s;
  endfunction

  function automatic scorer_item_t write_item(input logic [1:0] sel,
                                              input logic [ngfs_pkg::INDEX_WIDTH-1:0] idx,
                                              input logic [ngfs_pkg::VALUE_WIDTH-1:0] val,
                                              input logic [7:0] c, input logic l);
    scorer_item_t s;
    s      = '0;
    s.req  = ngfs_pkg::REQ_WRITE;
    s.sel  = sel;
    s.idx  = idx;
    s.val  = val;
    s.ch   = c;
    s.last = l;
    return s;
  endfunction

  localparam scorer_item_t OPENING [26] = '{
    zero_item(ngfs_pkg::CHAR_UPPER_A),
    write_item(ngfs_pkg::TBL_BI,    24'd675,      16'hFFFF, 8'h00, 1'b0),
    write_item(ngfs_pkg::TBL_TRI,   24'd17575,    16'hFFFF, 8'h00, 1'b0),
    write_item(ngfs_pkg::TBL_TETRA, 24'd456975,   16'hFFFF, 8'h00, 1'b0),
    write_item(ngfs_pkg::TBL_PENTA, 24'd11881375, 16'hFFFF, 8'h00, 1'b0),
    write_item(ngfs_pkg::TBL_PENTA, 24'd11881376, 16'h0000, 8'h00, 1'b0),
    write_item(ngfs_pkg::TBL_BI,    24'hFFFFFF,   16'h0000, 8'h00, 1'b0),
    write_item(ngfs_pkg::TBL_TRI,   24'd17576,    16'h0000, 8'h00, 1'b0),
    write_item(ngfs_pkg::TBL_TETRA, 24'd456976,   16'h0000, 8'h00, 1'b0),
    write_item(ngfs_pkg::TBL_TRI,   24'd0,        16'h1234, 8'h00, 1'b0),
    text_item(ngfs_pkg::CHAR_UPPER_Z, 1'b0),
    text_item(ngfs_pkg::CHAR_LOWER_Z, 1'b0),
    text_item(ngfs_pkg::CHAR_UPPER_Z, 1'b0),
    text_item(ngfs_pkg::CHAR_LOWER_Z, 1'b0),
    text_item(ngfs_pkg::CHAR_UPPER_Z, 1'b1),
    text_item(ngfs_pkg::CHAR_UPPER_Z, 1'b0),
    text_item(8'h40, 1'b0),
    text_item(ngfs_pkg::CHAR_UPPER_Z, 1'b0),
    text_item(8'h5B, 1'b0),
    text_item(8'h60, 1'b0),
    text_item(8'h7B, 1'b0),
    text_item(8'hFF, 1'b0),
    zero_item(8'h00),
    write_item(ngfs_pkg::TBL_BI, 24'd675, 16'h0000, ngfs_pkg::CHAR_UPPER_Z, 1'b1),
    text_item(ngfs_pkg::CHAR_UPPER_Z, 1'b0),
    zero_item(ngfs_pkg::CHAR_UPPER_Z)
  };

  function automatic int unsigned depth_of(input logic [1:0] sel);
    int unsigned d;
    d = ALPHA * ALPHA;
    for (int k = 0; k < sel; k++) d = d * ALPHA;
    return d;
  endfunction

  function automatic logic [5:0] to_letter(input logic [7:0] c);
    if (c >= ngfs_pkg::CHAR_UPPER_A && c <= ngfs_pkg::CHAR_UPPER_Z)
      return 6'(c - ngfs_pkg::CHAR_UPPER_A);
    if (c >= ngfs_pkg::CHAR_LOWER_A && c <= ngfs_pkg::CHAR_LOWER_Z)
      return 6'(c - ngfs_pkg::CHAR_LOWER_A);
    return NO_LETTER;
  endfunction

  // n letters ending at the incoming one, history[3] newest
  function automatic bit window_full(input int unsigned n);
    for (int j = 1; j < n; j++) if (history[4-j] == NO_LETTER) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit [25:0] window_key(input int unsigned n, input logic [5:0] cur);
    int unsigned idx = 0;
    for (int j = n - 1; j >= 1; j--) idx = idx * ALPHA + history[4-j];
    idx = idx * ALPHA + cur;
    return {2'(n - 2), 24'(idx)};
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] acc,
                                          input logic [ngfs_pkg::VALUE_WIDTH-1:0] w);
    logic [32:0] s;
    s = {1'b0, acc} + 33'(w);
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void clear_text();
    for (int k = 0; k < 4; k++) begin
      history[k]   = NO_LETTER;
      ngram_sum[k] = '0;
    end
  endfunction

  function automatic bit reads_known(input logic [5:0] cur);
    if (cur == NO_LETTER) return 1'b1;
    for (int n = 2; n <= 5; n++) begin
      if (!window_full(n)) break;
      if (!weights.exists(window_key(n, cur))) return 1'b0;
    end
    return 1'b1;
  endfunction

  // returns 1 when the item finishes a text, with its score
  function automatic bit advance_scorer(input scorer_item_t s,
                                        output logic [ngfs_pkg::SCORE_WIDTH-1:0] score);
    logic [5:0]  cur;
    logic [33:0] total;
    bit [25:0]   key;
    score = '0;
    if (s.req == ngfs_pkg::REQ_WRITE) begin
      if (s.idx < depth_of(s.sel)) weights[{s.sel, s.idx}] = s.val;
      return 1'b0;
    end
    cur = to_letter(s.ch);
    if (cur != NO_LETTER) begin
      for (int n = 2; n <= 5; n++) begin
        if (!window_full(n)) break;
        key = window_key(n, cur);
        ngram_sum[n-2] = sat_add(ngram_sum[n-2], weights.exists(key) ? weights[key] : '0);
      end
    end
    history = '{history[1], history[2], history[3], cur};
    if (!s.last) return 1'b0;
    total = 34'(ngram_sum[3]) + 34'(ngram_sum[2] >> 1) + 34'(ngram_sum[1] >> 2)
          + 34'(ngram_sum[0] >> 3);
    score = (total > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
    clear_text();
    return 1'b1;
  endfunction

  function automatic logic [ngfs_pkg::VALUE_WIDTH-1:0] rand_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return ngfs_pkg::VALUE_WIDTH'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [7:0] letter_char(input logic [4:0] code);
    return ($urandom_range(0, 1) ? ngfs_pkg::CHAR_UPPER_A : ngfs_pkg::CHAR_LOWER_A)
           + 8'(code);
  endfunction

  function automatic logic [7:0] non_letter();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (to_letter(c) != NO_LETTER);
    return c;
  endfunction

  // falls back to a window break when a letter would hit an unloaded entry
  function automatic logic [7:0] next_text_char();
    int unsigned r;
    logic [7:0]  c;
    r = $urandom_range(0, 99);
    if (r < 65) c = letter_char(load_set[$urandom_range(0, 2)]);
    else if (r < 80) c = letter_char(5'($urandom_range(0, ALPHA - 1)));
    else c = non_letter();
    if (!reads_known(to_letter(c))) c = non_letter();
    return c;
  endfunction

  function automatic scorer_item_t random_write();
    logic [1:0]                       sel;
    int unsigned                      d;
    logic [ngfs_pkg::INDEX_WIDTH-1:0] idx;
    sel = 2'($urandom_range(0, 3));
    d   = depth_of(sel);
    if ($urandom_range(0, 6) == 0)
      idx = ngfs_pkg::INDEX_WIDTH'($urandom_range(d, 24'hFFFFFF));
    else
      idx = ngfs_pkg::INDEX_WIDTH'($urandom_range(0, d - 1));
    return write_item(sel, idx, rand_weight(), 8'($urandom), 1'($urandom));
  endfunction

  task automatic send_item(input scorer_item_t s);
    logic [ngfs_pkg::SCORE_WIDTH-1:0] score;
    if (idle_on && !in_calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= s.req;
    in_char_code    <= s.ch;
    in_last         <= s.last;
    in_table_select <= s.sel;
    in_table_index  <= s.idx;
    in_table_value  <= s.val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (s.req == ngfs_pkg::REQ_WRITE) writes_sent++;
    if (advance_scorer(s, score)) pending_scores.push_back(s.chk ? s.want : score);
    if (items_sent % 50 == 0) in_calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic drain_scores();
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic run_random(input int unsigned n_items, input int unsigned n_texts);
    int unsigned  sent = 0;
    int unsigned  texts = 0;
    int unsigned  text_left = 0;
    scorer_item_t s;
    while (sent < n_items || texts < n_texts || text_left != 0) begin
      if ($urandom_range(0, 99) < 12) begin
        s = random_write();
      end else begin
        if (text_left == 0)
          text_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                  : $urandom_range(4, 16);
        s = text_item(next_text_char(), text_left == 1);
        text_left--;
        if (text_left == 0) texts++;
      end
      send_item(s);
      sent++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && !out_calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
    if (cycles % 256 == 0) out_calm = ($urandom_range(0, 2) == 0);
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d scores outstanding", cycles,
               pending_scores.size());
      $display("Verification failed");
      $finish;
    end
  end

  logic [ngfs_pkg::SCORE_WIDTH-1:0] want_score;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_scores.size() == 0) begin
        $display("%0t: score %0d with none expected", $time, out_score);
        errors++;
      end else begin
        want_score = pending_scores.pop_front();
        scores_checked++;
        if (want_score == 32'hFFFF_FFFF) scores_saturated++;
        if (out_score !== want_score) begin
          $display("%0t: score mismatch, expected %0d, got %0d", $time, want_score,
                   out_score);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned  t;
    int unsigned  idx;
    scorer_item_t s;
    clear_text();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (OPENING[i]) send_item(OPENING[i]);
    drain_scores();

    // load every n-gram over three random letters
    load_set[0] = 5'($urandom_range(0, ALPHA - 1));
    do load_set[1] = 5'($urandom_range(0, ALPHA - 1)); while (load_set[1] == load_set[0]);
    do load_set[2] = 5'($urandom_range(0, ALPHA - 1));
    while (load_set[2] == load_set[0] || load_set[2] == load_set[1]);
    for (int n = 2; n <= 5; n++) begin
      for (int k = 0; k < 3 ** n; k++) begin
        t   = k;
        idx = 0;
        for (int j = 0; j < n; j++) begin
          idx = idx * ALPHA + load_set[t % 3];
          t   = t / 3;
        end
        send_item(write_item(2'(n - 2), ngfs_pkg::INDEX_WIDTH'(idx), rand_weight(),
                             8'($urandom), 1'($urandom)));
      end
    end

    run_random(280, 24);
    drain_scores();

    // one long run of a single letter at full weight in every table
    send_item(write_item(ngfs_pkg::TBL_BI,    24'd675,      16'hFFFF, 8'h00, 1'b0));
    send_item(write_item(ngfs_pkg::TBL_TRI,   24'd17575,    16'hFFFF, 8'h00, 1'b0));
    send_item(write_item(ngfs_pkg::TBL_TETRA, 24'd456975,   16'hFFFF, 8'h00, 1'b0));
    send_item(write_item(ngfs_pkg::TBL_PENTA, 24'd11881375, 16'hFFFF, 8'h00, 1'b0));
    for (int k = 0; k < LONG_LEN; k++) begin
      s = text_item($urandom_range(0, 1) ? ngfs_pkg::CHAR_UPPER_Z : ngfs_pkg::CHAR_LOWER_Z,
                    k == LONG_LEN - 1);
      send_item(s);
    end

    idle_on = 1'b0;
    run_random(80, 0);
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d items sent, %0d table writes; %0d scores checked, %0d saturated",
             items_sent, writes_sent, scores_checked, scores_saturated);
    $display("random texts over letters %c%c%c, boundary bytes and a %0d-letter text",
             ngfs_pkg::CHAR_UPPER_A + 8'(load_set[0]),
             ngfs_pkg::CHAR_UPPER_A + 8'(load_set[1]),
             ngfs_pkg::CHAR_UPPER_A + 8'(load_set[2]), LONG_LEN);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/ngfs_pkg.sv
src/ngfs_ram.sv
src/ngram_fitness_scorer_core.sv
verif/ngram_fitness_scorer_core_tb.sv
